// ===== sv/tza_pkg.sv =====
// tza_pkg: shared types, constants and the month-length lookup for the
// time-zone date adjuster. No dependencies.
package tza_pkg;

	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int WDAY_W  = 3;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 12;
	localparam int ZONE_W  = 5;

	localparam int DATE_W  = SEC_W + MIN_W + HOUR_W + WDAY_W + DAY_W + MONTH_W + YEAR_W;
	localparam int TDATA_W = ((DATE_W + 7) / 8) * 8;

	localparam int ZONE_OFS_MIN   = -12;
	localparam int ZONE_OFS_MAX   = 12;
	localparam int ZONE_OFS_RESET = -3;

	localparam int HOURS_PER_DAY = 24;
	localparam int DAYS_PER_WEEK = 7;
	localparam int MONTHS        = 12;
	localparam int LEAP_FEB_LEN  = 29;
	localparam int LONG_MONTH    = 31;
	localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;

	// second sits in the lowest bits, matching the tdata layout
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [WDAY_W-1:0]  weekday;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} date_t;

	typedef logic [DAY_W-1:0] month_len_t [MONTHS];

	localparam month_len_t MONTH_LEN = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// out-of-range months count as 31 days; February is 29 days when year % 4 == 0
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic [YEAR_W-1:0] y);
		logic [DAY_W-1:0] len;
		if (m == '0 || m > MONTH_W'(MONTHS)) begin
			len = DAY_W'(LONG_MONTH);
		end else if (m == FEBRUARY && y[1:0] == 2'b00) begin
			len = DAY_W'(LEAP_FEB_LEN);
		end else begin
			len = MONTH_LEN[MONTH_W'(m - 4'd1)];
		end
		return len;
	endfunction

endpackage

// ===== sv/tza_date_step.sv =====
// tza_date_step: combinational hour offset, wrap and one-day calendar step.
// Depends on tza_pkg.
module tza_date_step (
	input  tza_pkg::date_t            d_in,
	input  logic signed [tza_pkg::ZONE_W-1:0] zone,
	output tza_pkg::date_t            d_out
);

	logic signed [6:0] hsum;
	logic              back;
	logic              fwd;
	logic [tza_pkg::MONTH_W-1:0] prev_month;
	logic [tza_pkg::YEAR_W-1:0]  prev_year;
	logic [tza_pkg::DAY_W-1:0]   cur_len;

	assign hsum = $signed({2'b00, d_in.hour}) + 7'(zone);
	assign back = hsum < 0;
	assign fwd  = hsum >= 7'sd24;

	always_comb begin
		if (d_in.month > 4'd1) begin
			prev_month = d_in.month - 4'd1;
			prev_year  = d_in.year;
		end else begin
			prev_month = tza_pkg::MONTH_W'(tza_pkg::MONTHS);
			prev_year  = d_in.year - 12'd1;
		end
	end

	assign cur_len = tza_pkg::month_days(d_in.month, d_in.year);

	always_comb begin
		d_out = d_in;
		if (back) begin
			d_out.hour    = tza_pkg::HOUR_W'(hsum + 7'sd24);
			d_out.weekday = (d_in.weekday > 3'd1) ? d_in.weekday - 3'd1
				: tza_pkg::WDAY_W'(tza_pkg::DAYS_PER_WEEK);
			if (d_in.day > 5'd1) begin
				d_out.day = d_in.day - 5'd1;
			end else begin
				d_out.month = prev_month;
				d_out.year  = prev_year;
				d_out.day   = tza_pkg::month_days(prev_month, prev_year);
			end
		end else if (fwd) begin
			d_out.hour    = tza_pkg::HOUR_W'(hsum - 7'sd24);
			d_out.weekday = (d_in.weekday < 3'd7) ? d_in.weekday + 3'd1 : 3'd1;
			if (d_in.day < cur_len) begin
				d_out.day = d_in.day + 5'd1;
			end else begin
				d_out.day = 5'd1;
				if (d_in.month < tza_pkg::MONTH_W'(tza_pkg::MONTHS)) begin
					d_out.month = d_in.month + 4'd1;
				end else begin
					d_out.month = 4'd1;
					d_out.year  = d_in.year + 12'd1;
				end
			end
		end else begin
			d_out.hour = tza_pkg::HOUR_W'(hsum);
		end
	end

endmodule

// ===== sv/timezone_date_adjust.sv =====
// timezone_date_adjust: top level; input register, date step, result register,
// zone offset register. Depends on tza_pkg and tza_date_step.
//
//   channel  | dir | handshake              | payload
//   s_axis   | in  | s_tvalid / s_tready    | s_tdata: reading
//   m_axis   | out | m_tvalid / m_tready    | m_tdata: adjusted reading
//   cfg      | in  | cfg_valid / cfg_ready  | cfg_data: zone offset, signed
//
// One reading per cycle unless m_tready stalls; result is held in date_s2.
// Throughput set by the single pass through tza_date_step between two registers.
// Reset clears both stage valids; zone offset resets to -3.
// Out-of-range offset writes (outside -12..12) are taken but ignored.
// A stall on m_tready backs up through both stages to s_tready.
module timezone_date_adjust (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [5:0] in_second, [11:6] in_minute, [16:12] in_hour, [19:17] in_weekday,
	// [24:20] in_day, [28:25] in_month, [40:29] in_year, rest zero
	input  logic [tza_pkg::TDATA_W-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [5:0] out_second, [11:6] out_minute, [16:12] out_hour, [19:17] out_weekday,
	// [24:20] out_day, [28:25] out_month, [40:29] out_year, rest zero
	output logic [tza_pkg::TDATA_W-1:0]   m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tza_pkg::ZONE_W-1:0]    cfg_data
);

	logic signed [tza_pkg::ZONE_W-1:0] zone_q;
	logic signed [tza_pkg::ZONE_W-1:0] cfg_val;
	logic            cfg_ok;
	logic            vld_s1, vld_s2;
	logic            adv_s2, adv_s1;
	tza_pkg::date_t  date_s1, date_s2, date_adj;

	assign cfg_ready = 1'b1;
	assign cfg_val   = $signed(cfg_data);
	assign cfg_ok    = cfg_val >= tza_pkg::ZONE_OFS_MIN && cfg_val <= tza_pkg::ZONE_OFS_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= tza_pkg::ZONE_W'(tza_pkg::ZONE_OFS_RESET);
		end else if (cfg_valid && cfg_ready && cfg_ok) begin
			zone_q <= cfg_val;
		end
	end

	assign adv_s2   = !vld_s2 || m_tready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			date_s1 <= tza_pkg::date_t'(s_tdata[tza_pkg::DATE_W-1:0]);
		end
		if (adv_s2 && vld_s1) begin
			date_s2 <= date_adj;
		end
	end

	tza_date_step u_step (
		.d_in  (date_s1),
		.zone  (zone_q),
		.d_out (date_adj)
	);

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(tza_pkg::TDATA_W - tza_pkg::DATE_W){1'b0}}, date_s2};

	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		zone_q >= tza_pkg::ZONE_OFS_MIN && zone_q <= tza_pkg::ZONE_OFS_MAX)
		else $error("zone offset register out of range");

	a_bad_cfg_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && !cfg_ok |=> $stable(zone_q))
		else $error("out-of-range offset write changed register");

	a_hour_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> date_s2.hour < tza_pkg::HOUR_W'(tza_pkg::HOURS_PER_DAY))
		else $error("result hour not wrapped");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted transaction lost from input stage");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s2 |=> vld_s1 && vld_s2)
		else $error("stalled stage dropped a transaction");

endmodule
